@@ hdl/beaver_triple_multiply_dot_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the Beaver triple multiply block
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef BEAVER_TRIPLE_MULTIPLY_DOT_ASSERT_SVH
`define BEAVER_TRIPLE_MULTIPLY_DOT_ASSERT_SVH

`ifndef ASSERT_OFF
// antecedent in a cycle implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// expression must never be true
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ hdl/btmd_pkg.sv @@
// ---------------------------------------------------------------------------
// btmd_pkg
// Shared types and constants of the Beaver triple multiply block.
// ---------------------------------------------------------------------------
package btmd_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned SLOT_W = 10;
   // slot widened far enough to compare against the largest store depth
   localparam int unsigned WIDE_W = 17;

   localparam int unsigned DEF_TRIPLE_DEPTH = 1024;
   localparam int unsigned DEF_QUEUE_DEPTH  = 4;

   // request codes
   localparam logic [1:0] REQ_LOAD    = 2'd0;
   localparam logic [1:0] REQ_MASK    = 2'd1;
   localparam logic [1:0] REQ_COMBINE = 2'd2;

   // decoded work item handed from front to back
   typedef struct packed {
      logic              combine;
      logic [WORD_W-1:0] v1;
      logic [WORD_W-1:0] v2;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      logic              last;
   } btmd_item_type;

   // queue status seen by the top level and the back
   typedef struct packed {
      logic empty;
      logic almost_full;
   } btmd_qstat_type;

endpackage

@@ hdl/beaver_triple_multiply_dot.sv @@
// ---------------------------------------------------------------------------
// beaver_triple_multiply_dot
// Party-zero Beaver triple multiplication with a running dot-product sum.
// ---------------------------------------------------------------------------
// Usage:
//   A request transfers when start is high and busy is low. req_type selects
//   load (write a, b, c at req_slot), mask (answer x - a and y - b) or
//   combine (answer z = d*e + d*b + e*a + c and the running dot sum).
//   Loads and unknown codes give no result.
//   Results appear on the rsp_ ports for one cycle with rsp_valid high; the
//   receiver always takes them. rsp_sum_done marks the final sum of a vector,
//   after which the accumulator restarts at zero.
// Timing:
//   An accepted request passes through a store read, the queue, three
//   arithmetic stages and the result register on its way to the rsp_ ports.
//   One request per cycle is taken while busy is low. The arithmetic pipeline
//   drains the queue every cycle, so the queue never holds more than one item
//   and busy stays low outside reset.
// Reset:
//   Synchronous reset empties the pipeline and queue and clears the sum;
//   busy is high while reset is held. The triple store is not cleared;
//   the user must read an entry only after its load; the block does not check.
// ---------------------------------------------------------------------------
`include "beaver_triple_multiply_dot_assert.svh"

module beaver_triple_multiply_dot
   import btmd_pkg::*;
#(
   parameter int unsigned TRIPLE_DEPTH = DEF_TRIPLE_DEPTH,
   parameter int unsigned QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_type,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic [WORD_W-1:0] req_first_value,
   input  logic [WORD_W-1:0] req_second_value,
   input  logic [WORD_W-1:0] req_third_value,
   input  logic              req_end_of_vector,
   output logic              rsp_valid,
   output logic [WORD_W-1:0] rsp_first_result,
   output logic [WORD_W-1:0] rsp_second_result,
   output logic [WORD_W-1:0] rsp_dot_sum,
   output logic              rsp_sum_done
);

   logic           accept;
   logic           push;
   logic           pop;
   btmd_item_type  push_item;
   btmd_item_type  head_item;
   btmd_qstat_type qstat;

   // request transfer
   assign busy   = qstat.almost_full || reset;
   assign accept = start && !busy;

   btmd_front #(
      .TRIPLE_DEPTH (TRIPLE_DEPTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .req_type          (req_type),
      .req_slot          (req_slot),
      .req_first_value   (req_first_value),
      .req_second_value  (req_second_value),
      .req_third_value   (req_third_value),
      .req_end_of_vector (req_end_of_vector),
      .push              (push),
      .push_item         (push_item)
   );

   btmd_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (qstat)
   );

   btmd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .qstat             (qstat),
      .head_item         (head_item),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_first_result  (rsp_first_result),
      .rsp_second_result (rsp_second_result),
      .rsp_dot_sum       (rsp_dot_sum),
      .rsp_sum_done      (rsp_sum_done)
   );

   // end-to-end checks: every accepted mask or combine answers, and every result traces back to one
   `ASSERT_IMPLY(top_work_answers, clock, reset, $past(accept && ((req_type == REQ_MASK) || (req_type == REQ_COMBINE)), 6), rsp_valid)
   `ASSERT_IMPLY(top_result_origin, clock, reset, rsp_valid, $past(accept && ((req_type == REQ_MASK) || (req_type == REQ_COMBINE)), 6))
   `ASSERT_IMPLY(top_done_origin, clock, reset, rsp_sum_done, $past(accept && (req_type == REQ_COMBINE) && req_end_of_vector, 6))

endmodule

@@ hdl/btmd_front.sv @@
// ---------------------------------------------------------------------------
// btmd_front
// Accepts requests, holds the triple store, classifies and forwards work.
// ---------------------------------------------------------------------------
module btmd_front
   import btmd_pkg::*;
#(
   parameter int unsigned TRIPLE_DEPTH = DEF_TRIPLE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          req_type,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [WORD_W-1:0]   req_first_value,
   input  logic [WORD_W-1:0]   req_second_value,
   input  logic [WORD_W-1:0]   req_third_value,
   input  logic                req_end_of_vector,
   output logic                push,
   output btmd_item_type       push_item
);

   localparam int unsigned IDX_W = (TRIPLE_DEPTH > 1) ? $clog2(TRIPLE_DEPTH) : 1;

   logic [WORD_W-1:0] a_mem [TRIPLE_DEPTH];
   logic [WORD_W-1:0] b_mem [TRIPLE_DEPTH];
   logic [WORD_W-1:0] c_mem [TRIPLE_DEPTH];

   logic [WIDE_W-1:0] slot_wide;
   logic [IDX_W-1:0]  addr;
   logic              in_range;
   logic              is_work;

   logic              valid_ff, valid_in;
   logic              combine_ff;
   logic              range_ff;
   logic              last_ff;
   logic [WORD_W-1:0] v1_ff, v2_ff;
   logic [WORD_W-1:0] rd_a_ff, rd_b_ff, rd_c_ff;

   // address decode and range check
   assign slot_wide = {{(WIDE_W-SLOT_W){1'b0}}, req_slot};
   assign addr      = slot_wide[IDX_W-1:0];
   assign in_range  = slot_wide < WIDE_W'(TRIPLE_DEPTH);
   assign is_work   = (req_type == REQ_MASK) || (req_type == REQ_COMBINE);
   assign valid_in  = accept && is_work;

   // triple store: load writes, mask and combine read
   always_ff @(posedge clock) begin
      if (accept && (req_type == REQ_LOAD) && in_range) begin
         a_mem[addr] <= req_first_value;
         b_mem[addr] <= req_second_value;
         c_mem[addr] <= req_third_value;
      end
      if (valid_in) begin
         rd_a_ff <= a_mem[addr];
         rd_b_ff <= b_mem[addr];
         rd_c_ff <= c_mem[addr];
      end
   end

   // item stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_in) begin
         combine_ff <= (req_type == REQ_COMBINE);
         range_ff   <= in_range;
         last_ff    <= req_end_of_vector;
         v1_ff      <= req_first_value;
         v2_ff      <= req_second_value;
      end
   end

   // out-of-range slots read as an all-zero triple
   assign push              = valid_ff;
   assign push_item.combine = combine_ff;
   assign push_item.v1      = v1_ff;
   assign push_item.v2      = v2_ff;
   assign push_item.a       = range_ff ? rd_a_ff : '0;
   assign push_item.b       = range_ff ? rd_b_ff : '0;
   assign push_item.c       = range_ff ? rd_c_ff : '0;
   assign push_item.last    = last_ff;

endmodule

@@ hdl/btmd_queue.sv @@
// ---------------------------------------------------------------------------
// btmd_queue
// Short FIFO of decoded items between the front and back halves.
// ---------------------------------------------------------------------------
`include "beaver_triple_multiply_dot_assert.svh"

module btmd_queue
   import btmd_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  btmd_item_type  push_item,
   input  logic           pop,
   output btmd_item_type  head_item,
   output btmd_qstat_type status
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   btmd_item_type    slots [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign do_push = push;
   assign do_pop  = pop && (count_ff != '0);

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item          = slots[rd_ptr_ff];
   assign status.empty       = (count_ff == '0);
   assign status.almost_full = (count_ff >= CNT_W'(QUEUE_DEPTH - 1));

   // checks
   `ASSERT_NEVER(q_no_overflow, clock, reset, push && !do_pop && (count_ff == CNT_W'(QUEUE_DEPTH)))
   `ASSERT_NEVER(q_count_bound, clock, reset, count_ff > CNT_W'(QUEUE_DEPTH))
   `ASSERT_NEXT(q_push_fills, clock, reset, push && !do_pop, !status.empty)

endmodule

@@ hdl/btmd_back.sv @@
// ---------------------------------------------------------------------------
// btmd_back
// Arithmetic pipeline: mask differences, product share and dot sum.
// ---------------------------------------------------------------------------
module btmd_back
   import btmd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  btmd_qstat_type    qstat,
   input  btmd_item_type     head_item,
   output logic              pop,
   output logic              rsp_valid,
   output logic [WORD_W-1:0] rsp_first_result,
   output logic [WORD_W-1:0] rsp_second_result,
   output logic [WORD_W-1:0] rsp_dot_sum,
   output logic              rsp_sum_done
);

   // stage valids and kinds
   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic              s1_comb_ff, s2_comb_ff, s3_comb_ff;
   logic              s1_last_ff, s2_last_ff, s3_last_ff;
   // stage 1: products and differences
   logic [WORD_W-1:0] p_de_ff, p_db_ff, p_ea_ff, c1_ff;
   logic [WORD_W-1:0] d1_ff, e1_ff;
   // stage 2: partial sums
   logic [WORD_W-1:0] sum_a_ff, sum_b_ff;
   logic [WORD_W-1:0] d2_ff, e2_ff;
   // stage 3: product share
   logic [WORD_W-1:0] z_ff;
   logic [WORD_W-1:0] d3_ff, e3_ff;
   // accumulator and output
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] total;
   logic              out_valid_ff;
   logic [WORD_W-1:0] out_first_ff, out_second_ff, out_sum_ff;
   logic              out_done_ff;

   // the pipeline never stalls, so the head is taken whenever present
   assign pop = !qstat.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         s1_valid_ff  <= pop;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
         acc_ff       <= acc_in;
      end
   end

   // stage 1: three independent multipliers, mask subtractions
   always_ff @(posedge clock) begin
      if (pop) begin
         s1_comb_ff <= head_item.combine;
         s1_last_ff <= head_item.last;
         p_de_ff    <= WORD_W'(head_item.v1 * head_item.v2);
         p_db_ff    <= WORD_W'(head_item.v1 * head_item.b);
         p_ea_ff    <= WORD_W'(head_item.v2 * head_item.a);
         c1_ff      <= head_item.c;
         d1_ff      <= head_item.v1 - head_item.a;
         e1_ff      <= head_item.v2 - head_item.b;
      end
   end

   // stage 2: pairwise sums
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_comb_ff <= s1_comb_ff;
         s2_last_ff <= s1_last_ff;
         sum_a_ff   <= p_de_ff + p_db_ff;
         sum_b_ff   <= p_ea_ff + c1_ff;
         d2_ff      <= d1_ff;
         e2_ff      <= e1_ff;
      end
   end

   // stage 3: product share z
   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         s3_comb_ff <= s2_comb_ff;
         s3_last_ff <= s2_last_ff;
         z_ff       <= sum_a_ff + sum_b_ff;
         d3_ff      <= d2_ff;
         e3_ff      <= e2_ff;
      end
   end

   // running dot sum, cleared after the last element
   assign total = acc_ff + z_ff;

   always_comb begin
      acc_in = acc_ff;
      if (s3_valid_ff && s3_comb_ff) begin
         acc_in = s3_last_ff ? '0 : total;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (s3_valid_ff) begin
         if (s3_comb_ff) begin
            out_first_ff  <= z_ff;
            out_second_ff <= '0;
            out_sum_ff    <= total;
            out_done_ff   <= s3_last_ff;
         end else begin
            out_first_ff  <= d3_ff;
            out_second_ff <= e3_ff;
            out_sum_ff    <= '0;
            out_done_ff   <= 1'b0;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_first_result  = out_first_ff;
   assign rsp_second_result = out_second_ff;
   assign rsp_dot_sum       = out_sum_ff;
   assign rsp_sum_done      = out_valid_ff && out_done_ff;

endmodule

@@ sim/tb_beaver_triple_multiply_dot.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_beaver_triple_multiply_dot
// Self-checking bench for the party-zero Beaver triple multiply block. A short
// table of corner requests runs first, then random load/mask/combine vectors
// with noise mixed in. Every accepted request is run through an in-bench
// share calculator, and each result transfer is compared field by field.
// ---------------------------------------------------------------------------
module tb_beaver_triple_multiply_dot;
   import btmd_pkg::*;

   localparam logic [1:0] REQ_UNUSED      = 2'd3;
   localparam int         STORE_DEPTH     = 1024;
   localparam int         RANDOM_REQUESTS = 550;
   localparam int         SETTLE_CYCLES   = 12;
   localparam logic [WORD_W-1:0] ALL_ONES = '1;

   typedef struct {
      logic [WORD_W-1:0] first;
      logic [WORD_W-1:0] second;
      logic [WORD_W-1:0] sum;
      logic              done;
   } share_result_type;

   typedef struct {
      logic [1:0]        kind;
      logic [SLOT_W-1:0] slot;
      logic [WORD_W-1:0] v1;
      logic [WORD_W-1:0] v2;
      logic [WORD_W-1:0] v3;
      logic              last;
      bit                has_known;
      share_result_type  known;
   } share_request_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [1:0]        req_type;
   logic [SLOT_W-1:0] req_slot;
   logic [WORD_W-1:0] req_first_value;
   logic [WORD_W-1:0] req_second_value;
   logic [WORD_W-1:0] req_third_value;
   logic              req_end_of_vector;
   logic              rsp_valid;
   logic [WORD_W-1:0] rsp_first_result;
   logic [WORD_W-1:0] rsp_second_result;
   logic [WORD_W-1:0] rsp_dot_sum;
   logic              rsp_sum_done;

   // typed expectation riding along with the request on the ports
   bit               row_has_known;
   share_result_type row_known;

   // share calculator state
   logic [WORD_W-1:0] calc_a [STORE_DEPTH];
   logic [WORD_W-1:0] calc_b [STORE_DEPTH];
   logic [WORD_W-1:0] calc_c [STORE_DEPTH];
   logic [WORD_W-1:0] calc_dot_sum;

   share_result_type  shares_due[$];
   share_request_type stim_rows[$];
   int                mismatches;
   int                requests_sent;
   int                sender_idle_pct;

   // slots written so far; mask and combine only read these
   bit slot_loaded [STORE_DEPTH];
   int loaded_slots[$];

   beaver_triple_multiply_dot dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_slot          (req_slot),
      .req_first_value   (req_first_value),
      .req_second_value  (req_second_value),
      .req_third_value   (req_third_value),
      .req_end_of_vector (req_end_of_vector),
      .rsp_valid         (rsp_valid),
      .rsp_first_result  (rsp_first_result),
      .rsp_second_result (rsp_second_result),
      .rsp_dot_sum       (rsp_dot_sum),
      .rsp_sum_done      (rsp_sum_done)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // one step of the party-zero share arithmetic; returns 1 when a result is due
   function automatic bit compute_share(input share_request_type rq,
                                        output share_result_type res);
      logic [WORD_W-1:0] a, b, c, z;
      res = '{default: '0};
      a = calc_a[rq.slot];
      b = calc_b[rq.slot];
      c = calc_c[rq.slot];
      case (rq.kind)
         REQ_LOAD: begin
            calc_a[rq.slot] = rq.v1;
            calc_b[rq.slot] = rq.v2;
            calc_c[rq.slot] = rq.v3;
            return 1'b0;
         end
         REQ_MASK: begin
            res.first  = rq.v1 - a;
            res.second = rq.v2 - b;
            return 1'b1;
         end
         REQ_COMBINE: begin
            z = rq.v1 * rq.v2 + rq.v1 * b + rq.v2 * a + c;
            calc_dot_sum = calc_dot_sum + z;
            res.first = z;
            res.sum   = calc_dot_sum;
            res.done  = rq.last;
            if (rq.last)
               calc_dot_sum = '0;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // result check and request capture, both at the rising edge
   always @(posedge clock) begin
      share_request_type seen;
      share_result_type  calc;
      share_result_type  due;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (shares_due.size() == 0) begin
               report_mismatch($sformatf("result with nothing outstanding, first_result %h",
                                         rsp_first_result));
            end else begin
               due = shares_due.pop_front();
               if (rsp_first_result !== due.first)
                  report_mismatch($sformatf("first_result %h, want %h",
                                            rsp_first_result, due.first));
               if (rsp_second_result !== due.second)
                  report_mismatch($sformatf("second_result %h, want %h",
                                            rsp_second_result, due.second));
               if (rsp_dot_sum !== due.sum)
                  report_mismatch($sformatf("dot_sum %h, want %h", rsp_dot_sum, due.sum));
               if (rsp_sum_done !== due.done)
                  report_mismatch($sformatf("sum_done %b, want %b", rsp_sum_done, due.done));
            end
         end else if (rsp_valid !== 1'b0) begin
            report_mismatch("rsp_valid unknown");
         end
         if (start && busy === 1'b0) begin
            seen.kind      = req_type;
            seen.slot      = req_slot;
            seen.v1        = req_first_value;
            seen.v2        = req_second_value;
            seen.v3        = req_third_value;
            seen.last      = req_end_of_vector;
            seen.has_known = row_has_known;
            seen.known     = row_known;
            if (compute_share(seen, calc))
               shares_due.insert(shares_due.size(), seen.has_known ? seen.known : calc);
         end
      end
   end

   function automatic share_request_type mk_request(
      input logic [1:0]        kind,
      input logic [SLOT_W-1:0] slot,
      input logic [WORD_W-1:0] v1,
      input logic [WORD_W-1:0] v2,
      input logic [WORD_W-1:0] v3,
      input logic              last,
      input bit                has_known = 1'b0,
      input logic [WORD_W-1:0] first = '0,
      input logic [WORD_W-1:0] second = '0,
      input logic [WORD_W-1:0] sum = '0,
      input logic              done = 1'b0);
      share_request_type rq;
      rq.kind      = kind;
      rq.slot      = slot;
      rq.v1        = v1;
      rq.v2        = v2;
      rq.v3        = v3;
      rq.last      = last;
      rq.has_known = has_known;
      rq.known     = '{first: first, second: second, sum: sum, done: done};
      return rq;
   endfunction

   // append one row to the corner table
   task automatic add_row(input share_request_type rq);
      stim_rows.insert(stim_rows.size(), rq);
   endtask

   // word biased toward the extremes
   function automatic logic [WORD_W-1:0] pick_word();
      int roll;
      roll = $urandom_range(0, 7);
      if (roll == 0)
         return '0;
      if (roll == 1)
         return ALL_ONES;
      return $urandom;
   endfunction

   function automatic logic [SLOT_W-1:0] pick_loaded_slot();
      return SLOT_W'(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
   endfunction

   // drive one request at the falling edge, hold it until the transfer
   task automatic send_request(input share_request_type rq);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         @(negedge clock);
         start             <= 1'b0;
         req_type          <= 2'($urandom);
         req_slot          <= SLOT_W'($urandom);
         req_first_value   <= $urandom;
         req_second_value  <= $urandom;
         req_third_value   <= $urandom;
         req_end_of_vector <= 1'($urandom);
      end
      @(negedge clock);
      start             <= 1'b1;
      req_type          <= rq.kind;
      req_slot          <= rq.slot;
      req_first_value   <= rq.v1;
      req_second_value  <= rq.v2;
      req_third_value   <= rq.v3;
      req_end_of_vector <= rq.last;
      row_has_known     <= rq.has_known;
      row_known         <= rq.known;
      do @(posedge clock); while (busy !== 1'b0);
      if (rq.kind == REQ_LOAD && !slot_loaded[rq.slot]) begin
         slot_loaded[rq.slot] = 1'b1;
         loaded_slots.insert(loaded_slots.size(), int'(rq.slot));
      end
      if (rq.kind != REQ_UNUSED)
         requests_sent++;
   endtask

   // stop sending until every outstanding result has come back
   task automatic hold_until_drained();
      @(negedge clock);
      start <= 1'b0;
      while (shares_due.size() != 0) @(posedge clock);
   endtask

   // main stimulus
   initial begin
      int                vec_len;
      logic [SLOT_W-1:0] s;
      start             = 1'b0;
      req_type          = REQ_LOAD;
      req_slot          = '0;
      req_first_value   = '0;
      req_second_value  = '0;
      req_third_value   = '0;
      req_end_of_vector = 1'b0;
      row_has_known     = 1'b0;
      row_known         = '{default: '0};
      calc_dot_sum      = '0;
      mismatches        = 0;
      requests_sent     = 0;
      sender_idle_pct   = 35;
      reset             = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // corner table: extremes, marker on non-combine items, unused code
      add_row(mk_request(REQ_LOAD, 10'd0, '0, '0, '0, 1'b0));
      add_row(mk_request(REQ_LOAD, 10'd1023, ALL_ONES, ALL_ONES, ALL_ONES, 1'b0));
      add_row(mk_request(REQ_LOAD, 10'd5, 32'd1, 32'd2, 32'd3, 1'b1));
      add_row(mk_request(REQ_MASK, 10'd0, ALL_ONES, '0, '0, 1'b1,
                         1'b1, ALL_ONES, '0, '0, 1'b0));
      add_row(mk_request(REQ_MASK, 10'd1023, '0, '0, ALL_ONES, 1'b0,
                         1'b1, 32'd1, 32'd1, '0, 1'b0));
      add_row(mk_request(REQ_COMBINE, 10'd0, ALL_ONES, ALL_ONES, '0, 1'b0,
                         1'b1, 32'd1, '0, 32'd1, 1'b0));
      add_row(mk_request(REQ_COMBINE, 10'd1023, '0, '0, '0, 1'b1,
                         1'b1, ALL_ONES, '0, '0, 1'b1));
      add_row(mk_request(REQ_UNUSED, 10'd0, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1));
      add_row(mk_request(REQ_COMBINE, 10'd0, '0, '0, '0, 1'b1,
                         1'b1, '0, '0, '0, 1'b1));
      add_row(mk_request(REQ_COMBINE, 10'd1023, ALL_ONES, ALL_ONES, '0, 1'b0));
      add_row(mk_request(REQ_COMBINE, 10'd5, 32'd7, 32'd9, '0, 1'b1));
      add_row(mk_request(REQ_MASK, 10'd5, '0, '0, '0, 1'b0));
      add_row(mk_request(REQ_LOAD, 10'd5, 32'hDEADBEEF, 32'h12345678,
                         32'hCAFEF00D, 1'b0));
      add_row(mk_request(REQ_MASK, 10'd5, 32'h80000000, 32'h7FFFFFFF, '0, 1'b0));
      add_row(mk_request(REQ_LOAD, 10'd512, ALL_ONES, '0, ALL_ONES, 1'b0));
      add_row(mk_request(REQ_COMBINE, 10'd5, 32'h89ABCDEF, 32'h01234567, '0, 1'b0));
      add_row(mk_request(REQ_COMBINE, 10'd512, ALL_ONES, 32'd2, '0, 1'b0));
      add_row(mk_request(REQ_COMBINE, 10'd1023, 32'h55555555, 32'hAAAAAAAA,
                         '0, 1'b1));
      add_row(mk_request(REQ_UNUSED, 10'd1023, '0, '0, '0, 1'b0));
      add_row(mk_request(REQ_MASK, 10'd512, ALL_ONES, ALL_ONES, '0, 1'b1));
      foreach (stim_rows[i])
         send_request(stim_rows[i]);
      hold_until_drained();

      // random vectors with noise; idle share rises at one third and drops to zero at two thirds
      requests_sent = 0;
      while (requests_sent < RANDOM_REQUESTS) begin
         if (requests_sent >= 2 * RANDOM_REQUESTS / 3 && sender_idle_pct != 0) begin
            hold_until_drained();
            sender_idle_pct = 0;
         end else if (requests_sent >= RANDOM_REQUESTS / 3 && sender_idle_pct == 35) begin
            hold_until_drained();
            sender_idle_pct = 46;
         end
         if ($urandom_range(0, 4) != 0) begin
            // well-formed dot product: per element load (sometimes), mask, combine
            vec_len = $urandom_range(1, 6);
            for (int k = 0; k < vec_len; k++) begin
               if ($urandom_range(0, 2) == 0) begin
                  s = SLOT_W'($urandom_range(0, STORE_DEPTH - 1));
                  send_request(mk_request(REQ_LOAD, s, pick_word(), pick_word(), pick_word(),
                                          1'($urandom)));
               end else begin
                  s = pick_loaded_slot();
               end
               send_request(mk_request(REQ_MASK, s, pick_word(), pick_word(), pick_word(),
                                       1'b0));
               send_request(mk_request(REQ_COMBINE, s, pick_word(), pick_word(), pick_word(),
                                       k == vec_len - 1));
            end
         end else begin
            // lone or broken items
            case ($urandom_range(0, 9))
               0, 1: send_request(mk_request(REQ_UNUSED, SLOT_W'($urandom), pick_word(),
                                             pick_word(), pick_word(), 1'($urandom)));
               2, 3, 4: send_request(mk_request(REQ_LOAD,
                                                SLOT_W'($urandom_range(0, STORE_DEPTH - 1)),
                                                pick_word(), pick_word(), pick_word(),
                                                1'($urandom)));
               5, 6, 7: send_request(mk_request(REQ_MASK, pick_loaded_slot(), pick_word(),
                                                pick_word(), pick_word(), 1'($urandom)));
               default: send_request(mk_request(REQ_COMBINE, pick_loaded_slot(), pick_word(),
                                                pick_word(), pick_word(), 1'($urandom)));
            endcase
         end
      end

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && shares_due.size() == 0)
         $display("tb_beaver_triple_multiply_dot OK");
      else
         $display("tb_beaver_triple_multiply_dot NOT OK");
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("tb_beaver_triple_multiply_dot NOT OK");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/btmd_pkg.sv
hdl/btmd_front.sv
hdl/btmd_queue.sv
hdl/btmd_back.sv
hdl/beaver_triple_multiply_dot.sv
sim/tb_beaver_triple_multiply_dot.sv
